// ----- sv/sem_pkg.sv -----
// ----------------------------------------------------------------------------
// Sobel edge map package
// Shared types and constants for the edge map front end, queue and back end.
// ----------------------------------------------------------------------------
package sem_pkg;

   localparam int unsigned CFG_W = 12;
   localparam int unsigned PIX_W = 8;
   localparam int unsigned RGB_W = 3 * PIX_W;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
   localparam logic [CFG_W-1:0] FRAME_MIN          = 12'd3;

   localparam int unsigned GRAY_SUM_W = 22;
   localparam logic [GRAY_SUM_W-1:0] GRAY_R_WEIGHT = 22'd4899;
   localparam logic [GRAY_SUM_W-1:0] GRAY_G_WEIGHT = 22'd9617;
   localparam logic [GRAY_SUM_W-1:0] GRAY_B_WEIGHT = 22'd1868;
   localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND    = 22'd8192;
   localparam int unsigned GRAY_SHIFT = 14;

   localparam int unsigned MAG_SQ_W = 21;
   // Largest squared magnitude whose rounded-up root stays below 255.
   localparam logic [MAG_SQ_W-1:0] MAG_SQ_LIMIT = 21'd64516;
   localparam logic [PIX_W-1:0] LEVEL_MAX = 8'd255;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;
   localparam int unsigned QCNT_W      = 3;

   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
      logic             emit;
      logic             done;
   } win_entry_type;

endpackage

// ----- sv/sem_front.sv -----
// ----------------------------------------------------------------------------
// Sobel edge map front end
// Accepts pixels, tracks row and column, converts to gray and reads the
// two line stores, then queues one window column per pixel.
// ----------------------------------------------------------------------------
module sem_front import sem_pkg::*; #(
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [RGB_W-1:0]    req_tdata,
   input  logic                req_tuser,
   input  logic [CFG_W-1:0]    frame_width,
   input  logic [CFG_W-1:0]    frame_height,
   input  logic                q_full,
   output logic                q_push,
   output win_entry_type       q_entry
);

   localparam int unsigned CW   = $clog2(MAX_WIDTH);
   localparam int unsigned CMPW = 14;

   typedef enum logic {F_IDLE, F_READ} front_state_type;

   front_state_type        state_ff;
   logic [CW-1:0]          col_ff, col_in;
   logic [CFG_W-1:0]       row_ff, row_in;
   logic [RGB_W-1:0]       pix_ff;
   logic [CW-1:0]          addr_ff;
   logic                   emit_ff, done_ff;
   logic [2*PIX_W-1:0]     rd_ff;
   logic [2*PIX_W-1:0]     line_mem_ff [MAX_WIDTH];

   logic [CFG_W-1:0]       w_eff, h_eff;
   logic [CW-1:0]          col_cur;
   logic [CFG_W-1:0]       row_cur;
   logic [CMPW-1:0]        col_x, row_x, w_x, h_x, col_inc, row_inc;
   logic                   emit_now, done_now, accept;
   logic [GRAY_SUM_W-1:0]  gray_sum;
   logic [PIX_W-1:0]       gray;

   always_comb begin
      w_eff = frame_width;
      if (frame_width < FRAME_MIN) begin
         w_eff = FRAME_MIN;
      end
      if (CMPW'(frame_width) > CMPW'(MAX_WIDTH)) begin
         w_eff = CFG_W'(MAX_WIDTH);
      end
      h_eff = (frame_height < FRAME_MIN) ? FRAME_MIN : frame_height;
   end

   assign col_cur = req_tuser ? '0 : col_ff;
   assign row_cur = req_tuser ? '0 : row_ff;
   assign col_x   = CMPW'(col_cur);
   assign row_x   = CMPW'(row_cur);
   assign w_x     = CMPW'(w_eff);
   assign h_x     = CMPW'(h_eff);

   assign emit_now = (row_x >= CMPW'(2)) && (col_x >= CMPW'(2)) &&
                     (row_x < h_x) && (col_x < w_x);
   assign done_now = (row_x == h_x - CMPW'(1)) && (col_x == w_x - CMPW'(1));

   always_comb begin
      col_inc = col_x + CMPW'(1);
      row_inc = row_x + CMPW'(1);
      if (col_inc >= w_x) begin
         col_in = '0;
         row_in = (row_inc >= h_x) ? '0 : row_inc[CFG_W-1:0];
      end else begin
         col_in = col_inc[CW-1:0];
         row_in = row_cur;
      end
   end

   assign req_tready = (state_ff == F_IDLE) && !q_full;
   assign accept     = req_tvalid && req_tready;

   assign gray_sum = GRAY_R_WEIGHT * GRAY_SUM_W'(pix_ff[3*PIX_W-1:2*PIX_W]) +
                     GRAY_G_WEIGHT * GRAY_SUM_W'(pix_ff[2*PIX_W-1:PIX_W]) +
                     GRAY_B_WEIGHT * GRAY_SUM_W'(pix_ff[PIX_W-1:0]) + GRAY_ROUND;
   assign gray     = gray_sum[GRAY_SHIFT+PIX_W-1:GRAY_SHIFT];

   assign q_push        = (state_ff == F_READ);
   assign q_entry.top   = rd_ff[2*PIX_W-1:PIX_W];
   assign q_entry.mid   = rd_ff[PIX_W-1:0];
   assign q_entry.bot   = gray;
   assign q_entry.emit  = emit_ff;
   assign q_entry.done  = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (accept) begin
                  state_ff <= F_READ;
                  col_ff   <= col_in;
                  row_ff   <= row_in;
               end
            end
            F_READ: begin
               state_ff <= F_IDLE;
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff  <= req_tdata;
         addr_ff <= col_cur;
         emit_ff <= emit_now;
         done_ff <= done_now;
         rd_ff   <= line_mem_ff[col_cur];
      end
      if (state_ff == F_READ) begin
         line_mem_ff[addr_ff] <= {rd_ff[PIX_W-1:0], gray};
      end
   end

endmodule

// ----- sv/sem_queue.sv -----
// ----------------------------------------------------------------------------
// Sobel edge map window queue
// Short first-in first-out store of window columns between front and back end.
// ----------------------------------------------------------------------------
module sem_queue import sem_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  win_entry_type push_entry,
   input  logic          pop,
   output win_entry_type pop_entry,
   output logic          full,
   output logic          empty
);

   win_entry_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic               do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- sv/sem_back.sv -----
// ----------------------------------------------------------------------------
// Sobel edge map back end
// Shifts window columns through the taps, forms the Sobel gradients and
// finds the rounded-up magnitude with a two-bits-per-cycle square root.
// ----------------------------------------------------------------------------
module sem_back import sem_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  win_entry_type    q_entry,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [PIX_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);

   localparam int unsigned GW = PIX_W + 3;
   localparam int unsigned SW = 16;
   localparam int unsigned RW = 11;

   typedef enum logic [1:0] {B_IDLE, B_SQUARE, B_ROOT, B_DONE} back_state_type;

   back_state_type         state_ff;
   logic [PIX_W-1:0]       taps_ff [6];
   logic signed [GW-1:0]   gx_ff, gy_ff;
   logic [SW-1:0]          s_ff;
   logic                   sat_ff;
   logic [RW-1:0]          rem_ff, rem_in;
   logic [PIX_W-1:0]       q_ff, q_in;
   logic [2:0]             step_ff;
   logic                   done_ff;
   logic                   out_valid_ff;
   logic [PIX_W-1:0]       out_level_ff;
   logic                   out_last_ff;

   logic [GW-1:0]          x_pos, x_neg, y_pos, y_neg;
   logic [GW-1:0]          gx_neg, gy_neg;
   logic [GW-2:0]          gx_abs, gy_abs;
   logic [MAG_SQ_W-1:0]    mag_sq;
   logic [RW-1:0]          rem_sh, trial;
   logic [PIX_W:0]         mag, level_wide;
   logic [PIX_W-1:0]       level;
   logic                   out_free;

   assign q_pop = (state_ff == B_IDLE) && !q_empty;

   // Left column is taps 3..5, centre column taps 0..2, right column the entry.
   assign x_pos = GW'(q_entry.top) + {2'b0, q_entry.mid, 1'b0} + GW'(q_entry.bot);
   assign x_neg = GW'(taps_ff[3]) + {2'b0, taps_ff[4], 1'b0} + GW'(taps_ff[5]);
   assign y_pos = GW'(taps_ff[5]) + {2'b0, taps_ff[2], 1'b0} + GW'(q_entry.bot);
   assign y_neg = GW'(taps_ff[3]) + {2'b0, taps_ff[0], 1'b0} + GW'(q_entry.top);

   assign gx_neg = GW'(-gx_ff);
   assign gy_neg = GW'(-gy_ff);
   assign gx_abs = gx_ff[GW-1] ? gx_neg[GW-2:0] : gx_ff[GW-2:0];
   assign gy_abs = gy_ff[GW-1] ? gy_neg[GW-2:0] : gy_ff[GW-2:0];
   assign mag_sq = MAG_SQ_W'(gx_abs) * MAG_SQ_W'(gx_abs) +
                   MAG_SQ_W'(gy_abs) * MAG_SQ_W'(gy_abs);

   always_comb begin
      rem_sh = {rem_ff[RW-3:0], s_ff[SW-1:SW-2]};
      trial  = RW'({q_ff, 2'b01});
      if (rem_sh >= trial) begin
         rem_in = rem_sh - trial;
         q_in   = {q_ff[PIX_W-2:0], 1'b1};
      end else begin
         rem_in = rem_sh;
         q_in   = {q_ff[PIX_W-2:0], 1'b0};
      end
   end

   assign mag        = {1'b0, q_ff} + (PIX_W+1)'(rem_ff != '0);
   assign level_wide = (PIX_W+1)'(LEVEL_MAX) - mag;
   assign level      = sat_ff ? '0 : level_wide[PIX_W-1:0];
   assign out_free   = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_level_ff;
   assign rsp_tlast  = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            taps_ff[i] <= '0;
         end
      end else begin
         if (out_valid_ff && rsp_tready && (state_ff != B_DONE)) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  taps_ff[3] <= taps_ff[0];
                  taps_ff[4] <= taps_ff[1];
                  taps_ff[5] <= taps_ff[2];
                  taps_ff[0] <= q_entry.top;
                  taps_ff[1] <= q_entry.mid;
                  taps_ff[2] <= q_entry.bot;
                  if (q_entry.emit) begin
                     state_ff <= B_SQUARE;
                  end
               end
            end
            B_SQUARE: begin
               state_ff <= B_ROOT;
            end
            B_ROOT: begin
               if (step_ff == '0) begin
                  state_ff <= B_DONE;
               end
            end
            B_DONE: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  state_ff     <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            gx_ff   <= $signed(x_pos) - $signed(x_neg);
            gy_ff   <= $signed(y_pos) - $signed(y_neg);
            done_ff <= q_entry.done;
         end
         B_SQUARE: begin
            sat_ff  <= (mag_sq > MAG_SQ_LIMIT);
            s_ff    <= mag_sq[SW-1:0];
            rem_ff  <= '0;
            q_ff    <= '0;
            step_ff <= 3'd7;
         end
         B_ROOT: begin
            rem_ff  <= rem_in;
            q_ff    <= q_in;
            s_ff    <= {s_ff[SW-3:0], 2'b00};
            step_ff <= step_ff - 3'd1;
         end
         B_DONE: begin
            if (out_free) begin
               out_level_ff <= level;
               out_last_ff  <= done_ff;
            end
         end
         default: begin
            done_ff <= 1'b0;
         end
      endcase
   end

endmodule

// ----- sv/sobel_edge_map.sv -----
// ----------------------------------------------------------------------------
// Sobel edge map
// Streaming 3x3 Sobel edge detector on colour pixels in raster order.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ stream, one item per pixel, with req_tuser high on
// the first pixel of a frame. Each pixel is converted to gray and written to
// two line stores; once a full 3x3 window is present the block gives one
// rsp_ item for the centre pixel: 255 minus the rounded-up gradient magnitude,
// clamped at 0. Border pixels give no item. rsp_tlast is high on the item of
// the last interior pixel of the frame.
// The frame size is set through the csr_ port; the user must set it only while
// the stream is idle, as the block does not enforce this. The front end takes
// no new pixel while it queues the last one or the queue is full. The back end
// shifts a border column into the window; an interior pixel passes the square,
// root and done states, the root taking two bits of the squared magnitude per
// cycle. A four-entry queue and the output register let the front end keep
// taking pixels while the receiver stalls, until the queue is full.
// Reset restores the frame size to 640 by 480, clears the counters and window
// and empties the queue; line store contents are undefined until written.
// ----------------------------------------------------------------------------
module sobel_edge_map import sem_pkg::*; #(
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [RGB_W-1:0] req_tdata,   // red_in, green_in, blue_in
   input  logic             req_tuser,   // frame_start
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [PIX_W-1:0] rsp_tdata,   // edge_level
   output logic             rsp_tlast,
   input  logic             csr_we,
   input  logic             csr_addr,
   input  logic [CFG_W-1:0] csr_wdata
);

   logic [CFG_W-1:0] frame_width_ff;
   logic [CFG_W-1:0] frame_height_ff;
   logic             q_full, q_empty, q_push, q_pop;
   win_entry_type    push_entry, pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: begin
               frame_width_ff <= frame_width_ff;
            end
         endcase
      end
   end

   sem_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_entry      (push_entry)
   );

   sem_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   sem_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_entry    (pop_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
